// File: design/tks_pkg.sv
// Shared types and constants for the top-k sorted insertion block.
`default_nettype none
package tks_pkg;

    // Field widths fixed by the interface
    localparam int POS_W   = 7;
    localparam int VALUE_W = 32;

    // Input command codes (s_tuser)
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    // Result kind codes (m_tuser[0])
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_REPORT,
        S_READ
    } state_t;

    // What each cell does in a cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT
    } cell_mode_t;

    // Control broadcast to every cell of the chain
    typedef struct packed {
        cell_mode_t                  mode;
        logic signed [VALUE_W-1:0]   value;
    } cell_ctrl_t;

endpackage
`default_nettype wire

// File: design/tks_cell.sv
// One cell of the sorted chain: holds one kept value and its compare flag.
`default_nettype none
module tks_cell (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire tks_pkg::cell_ctrl_t                 ctrl,
    input  wire logic                                active,
    input  wire logic signed [tks_pkg::VALUE_W-1:0]  left_value,
    input  wire logic                                left_ge,
    input  wire logic signed [tks_pkg::VALUE_W-1:0]  right_value,
    output logic signed [tks_pkg::VALUE_W-1:0]       value,
    output logic                                     ge,
    output logic                                     ge_q
);

    logic signed [tks_pkg::VALUE_W-1:0] value_reg;
    logic signed [tks_pkg::VALUE_W-1:0] value_next;
    logic                               ge_reg;

    // Entry counts towards the position when it is in use and not below the new value
    assign ge = active && (value_reg >= ctrl.value);

    // Hold, make room for the new value, or move up during readout
    always_comb begin
        value_next = value_reg;
        case (ctrl.mode)
            tks_pkg::CELL_INSERT: begin
                if (!ge) begin
                    value_next = left_ge ? ctrl.value : left_value;
                end
            end
            tks_pkg::CELL_SHIFT: begin
                value_next = right_value;
            end
            default: begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    // Keep the compare result for the position encoder
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ge_reg <= 1'b0;
        end else if (ctrl.mode == tks_pkg::CELL_INSERT) begin
            ge_reg <= ge;
        end
    end

    assign value = value_reg;
    assign ge_q  = ge_reg;

endmodule
`default_nettype wire

// File: design/tks_pos_enc.sv
// Turns the prefix of set compare flags into the insert position.
`default_nettype none
module tks_pos_enc #(
    parameter int DEPTH = 64
) (
    input  wire logic [DEPTH-1:0]           ge_q,
    output logic      [tks_pkg::POS_W-1:0]  position
);

    // The flags form a prefix; mark the one boundary and OR its index in
    always_comb begin
        position = '0;
        for (int i = 0; i <= DEPTH; i++) begin
            if (((i == 0) || ge_q[(i == 0) ? 0 : i - 1]) &&
                ((i == DEPTH) || !ge_q[(i == DEPTH) ? 0 : i])) begin
                position = position | tks_pkg::POS_W'(i);
            end
        end
    end

endmodule
`default_nettype wire

// File: design/top_k_sorted_insert.sv
// Insert: accepted in idle; report loaded once output is free; no input taken until then.
// Finish: n values read one per cycle via cell 0 while output free; empty: one invalid result.
// Compare and shift happen in all cells at once; the encoder uses the registered flags.
// Output register lets a new item enter while a result still waits for m_tready.
// Reset (aresetn low, synchronous): list empty, keep count 1, no result pending.
`default_nettype none
module top_k_sorted_insert #(
    parameter int DEPTH = 64
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Configuration: keep_count
    input  wire logic                           cfg_we,
    input  wire logic [tks_pkg::POS_W-1:0]      cfg_wdata,
    // Input stream
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [31:0]                    s_tdata,  // [31:0] value
    input  wire logic [0:0]                     s_tuser,  // [0] command
    // Result stream
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [39:0]                         m_tdata,  // [6:0] position, [38:7] out_value
    output logic [1:0]                          m_tuser,  // [0] kind, [1] valid_res
    output logic                                m_tlast
);

    localparam int PW = tks_pkg::POS_W;
    localparam int VW = tks_pkg::VALUE_W;

    tks_pkg::state_t     state_reg, state_next;
    tks_pkg::cell_ctrl_t cell_ctrl;

    logic [PW-1:0] keep_count_reg;
    logic [PW-1:0] count_reg, count_next;
    logic [PW-1:0] rd_idx_reg, rd_idx_next;
    logic [PW-1:0] k_eff, n_eff, enc_pos;
    logic          rd_last, out_free, load;

    logic          m_tvalid_reg;
    logic          res_kind, res_valid, res_last;
    logic [PW-1:0] res_pos;
    logic [VW-1:0] res_value;
    logic          kind_reg, valid_reg, last_reg;
    logic [PW-1:0] pos_reg;
    logic [VW-1:0] value_reg;

    logic signed [VW-1:0] cell_val   [DEPTH];
    logic signed [VW-1:0] left_val   [DEPTH];
    logic signed [VW-1:0] right_val  [DEPTH];
    logic [DEPTH-1:0]     cell_ge, left_ge, ge_q, active;

    // Keep count register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            keep_count_reg <= PW'(1);
        end else if (cfg_we) begin
            keep_count_reg <= cfg_wdata;
        end
    end

    // Effective k and the number of entries that take part
    always_comb begin
        if (keep_count_reg == '0) begin
            k_eff = PW'(1);
        end else if (keep_count_reg > PW'(DEPTH)) begin
            k_eff = PW'(DEPTH);
        end else begin
            k_eff = keep_count_reg;
        end
        n_eff = (count_reg > k_eff) ? k_eff : count_reg;
    end

    assign rd_last  = (PW'(rd_idx_reg + PW'(1)) == n_eff);
    assign out_free = !m_tvalid_reg || m_tready;

    // Chain of cells
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        assign active[g] = (PW'(g) < n_eff);
        if (g == 0) begin : g_head
            assign left_val[g] = cell_ctrl.value;
            assign left_ge[g]  = 1'b1;
        end else begin : g_body
            assign left_val[g] = cell_val[g-1];
            assign left_ge[g]  = cell_ge[g-1];
        end
        if (g == DEPTH - 1) begin : g_tail
            assign right_val[g] = cell_val[g];
        end else begin : g_mid
            assign right_val[g] = cell_val[g+1];
        end

        tks_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (cell_ctrl),
            .active      (active[g]),
            .left_value  (left_val[g]),
            .left_ge     (left_ge[g]),
            .right_value (right_val[g]),
            .value       (cell_val[g]),
            .ge          (cell_ge[g]),
            .ge_q        (ge_q[g])
        );
    end

    tks_pos_enc #(.DEPTH(DEPTH)) u_pos_enc (
        .ge_q     (ge_q),
        .position (enc_pos)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tks_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    state_next = (s_tuser[0] == tks_pkg::CMD_INSERT) ? tks_pkg::S_REPORT
                                                                     : tks_pkg::S_READ;
                end
            end
            tks_pkg::S_REPORT: begin
                if (out_free) begin
                    state_next = tks_pkg::S_IDLE;
                end
            end
            tks_pkg::S_READ: begin
                if (out_free && ((n_eff == '0) || rd_last)) begin
                    state_next = tks_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = tks_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        s_tready        = 1'b0;
        cell_ctrl.mode  = tks_pkg::CELL_HOLD;
        cell_ctrl.value = s_tdata;
        load            = 1'b0;
        rd_idx_next     = rd_idx_reg;
        count_next      = count_reg;
        res_kind        = tks_pkg::KIND_INSERT;
        res_pos         = '0;
        res_value       = '0;
        res_valid       = 1'b0;
        res_last        = 1'b1;
        case (state_reg)
            tks_pkg::S_IDLE: begin
                s_tready    = 1'b1;
                rd_idx_next = '0;
                if (s_tvalid && (s_tuser[0] == tks_pkg::CMD_INSERT)) begin
                    cell_ctrl.mode = tks_pkg::CELL_INSERT;
                end
            end
            tks_pkg::S_REPORT: begin
                if (out_free) begin
                    load = 1'b1;
                    if (enc_pos >= k_eff) begin
                        res_pos    = k_eff;
                        count_next = n_eff;
                    end else begin
                        res_pos    = enc_pos;
                        res_valid  = 1'b1;
                        count_next = (n_eff < k_eff) ? PW'(n_eff + PW'(1)) : k_eff;
                    end
                end
            end
            tks_pkg::S_READ: begin
                res_kind = tks_pkg::KIND_READ;
                if (out_free) begin
                    load = 1'b1;
                    if (n_eff == '0) begin
                        count_next = '0;
                    end else begin
                        res_pos        = rd_idx_reg;
                        res_value      = cell_val[0];
                        res_valid      = 1'b1;
                        res_last       = rd_last;
                        cell_ctrl.mode = tks_pkg::CELL_SHIFT;
                        rd_idx_next    = PW'(rd_idx_reg + PW'(1));
                        if (rd_last) begin
                            count_next = '0;
                        end
                    end
                end
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= tks_pkg::S_IDLE;
            count_reg    <= '0;
            rd_idx_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rd_idx_reg <= rd_idx_next;
            if (load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Result payload register
    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg  <= res_kind;
            pos_reg   <= res_pos;
            value_reg <= res_value;
            valid_reg <= res_valid;
            last_reg  <= res_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, value_reg, pos_reg};
    assign m_tuser  = {valid_reg, kind_reg};
    assign m_tlast  = last_reg;

`ifndef SYNTHESIS
    a_insert_to_report: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser[0] == tks_pkg::CMD_INSERT))
        |=> (state_reg == tks_pkg::S_REPORT))
        else $error("insert transaction did not move to report");

    a_pos_within_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tks_pkg::S_REPORT) |-> (enc_pos <= count_reg))
        else $error("insert position beyond kept entries");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= PW'(DEPTH))
        else $error("kept count exceeds depth");

    a_readout_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == tks_pkg::S_READ) && out_free && ((n_eff == '0) || rd_last))
        |=> (count_reg == '0))
        else $error("list not cleared after readout");
`endif

endmodule
`default_nettype wire
